[rtl/i2cmbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
package i2cmbs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd4;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_HEADER = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_END    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOACK  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [19:0] FREQ_RESET    = 20'd100000;
    localparam logic [7:0]  OVH_RESET     = 8'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [8:0]  HALF_RESET    = 9'd5;
    localparam logic [8:0]  HALF_MAX      = 9'd511;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    localparam logic [4:0]  DIV_LAST      = 5'd19;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  device_address;
        logic        read_message;
        logic        no_stop;
        logic [15:0] byte_count;
        logic [7:0]  write_data;
        logic        sda_level;
        logic        scl_level;
    } item_in_t;

    typedef struct packed {
        logic        scl_drive;
        logic        sda_drive;
        logic        ready_res;
        logic [7:0]  read_data;
        logic        read_valid;
        logic        message_done;
        logic [1:0]  status;
    } item_out_t;

    typedef struct packed {
        logic [15:0] ack_timeout;
        logic        stretch_en;
        logic        delay_en;
        logic [8:0]  half_period;
    } timing_t;

endpackage

[rtl/i2cmbs_div.sv]
// Serial divider that derives the SCL half period from the bus frequency.
module i2cmbs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [19:0] freq_in,
    input  logic [7:0]  ovh_in,
    output logic        busy,
    output logic [8:0]  half_period
);

    localparam logic [8:0] HALF_MAX_L = i2cmbs_pkg::HALF_MAX;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [19:0] dvd_reg;
    logic [21:0] rem_reg;
    logic [19:0] quo_reg;
    logic [20:0] den_reg;
    logic [7:0]  ovh_reg;
    logic [8:0]  half_reg;

    logic [21:0] trial;
    logic        fits;
    logic [19:0] quo_next;
    logic [19:0] diff;
    logic [8:0]  half_next;

    always_comb begin
        trial    = {rem_reg[20:0], dvd_reg[19]};
        fits     = trial >= {1'b0, den_reg};
        quo_next = {quo_reg[18:0], fits};
        diff     = (quo_next > {12'd0, ovh_reg}) ? (quo_next - {12'd0, ovh_reg}) : 20'd0;
        half_next = (diff > {11'd0, HALF_MAX_L}) ? HALF_MAX_L : diff[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            half_reg <= i2cmbs_pkg::HALF_RESET;
        end else if (start) begin
            if (freq_in == 20'd0) begin
                busy_reg <= 1'b0;
                half_reg <= i2cmbs_pkg::HALF_MAX;
            end else begin
                busy_reg <= 1'b1;
            end
            cnt_reg <= 5'd0;
            dvd_reg <= i2cmbs_pkg::US_PER_SEC;
            rem_reg <= 22'd0;
            quo_reg <= 20'd0;
            den_reg <= {freq_in, 1'b0};
            ovh_reg <= ovh_in;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= quo_next;
            dvd_reg <= {dvd_reg[18:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == i2cmbs_pkg::DIV_LAST) begin
                busy_reg <= 1'b0;
                half_reg <= half_next;
            end
        end
    end

    assign busy        = busy_reg;
    assign half_period = half_reg;

endmodule

[rtl/i2cmbs_fifo.sv]
// Short item queue between the accepting front and the bus sequencer.
module i2cmbs_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  i2cmbs_pkg::item_in_t  push_item,
    input  logic                  pop,
    output i2cmbs_pkg::item_in_t  head_item,
    output logic                  empty,
    output logic                  full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    i2cmbs_pkg::item_in_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = slot_reg[rd_ptr_reg];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_CNT);

endmodule

[rtl/i2cmbs_seq.sv]
// Bus sequencer: runs one tick of the I2C bit sequence per item and registers the result.
module i2cmbs_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  i2cmbs_pkg::item_in_t   item,
    input  i2cmbs_pkg::timing_t    timing,
    input  logic                   m_ready,
    output logic                   m_valid,
    output i2cmbs_pkg::item_out_t  m_item
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_SCLH, PH_START_SDAL, PH_START_SCLL,
        PH_BIT_SDA, PH_BIT_SCLH, PH_BIT_SCLL,
        PH_ACK_SDAH, PH_ACK_SCLH, PH_ACK_POLL, PH_ACK_REST, PH_POST_SCLL,
        PH_RD_SDAH, PH_RD_SCLH, PH_RD_SCLL, PH_RD_ASDA, PH_RD_ASCLH, PH_RD_ASCLL,
        PH_STOP_SDAL, PH_STOP_SCLH, PH_STOP_SDAH, PH_REL_SCLH, PH_REL_SDAH
    } phase_t;

    typedef struct packed {
        logic        done;
        logic [16:0] wc;
    } scl_res_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] wc_reg, wc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] bytes_reg, bytes_next;
    logic        prev_rd_reg, prev_rd_next;
    logic        open_reg, open_next;
    logic        rd_flag_reg, rd_flag_next;
    logic        nostop_reg, nostop_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        valid_reg;
    i2cmbs_pkg::item_out_t res_reg, res_next;

    function automatic scl_res_t scl_step(input logic [16:0] e, input logic [8:0] d,
                                          input logic high, input logic stretch,
                                          input logic scl_in, input logic [15:0] tmo);
        scl_res_t r;
        logic [16:0] over;
        over   = e - {8'd0, d};
        r.done = (e >= {8'd0, d});
        if (r.done && high && stretch && !scl_in && (over < {1'b0, tmo})) begin
            r.done = 1'b0;
        end
        r.wc = r.done ? 17'd0 : e + 17'd1;
        return r;
    endfunction

    always_comb begin
        logic        accepted;
        logic [8:0]  dly;
        logic [8:0]  rem;
        scl_res_t    sr;
        logic        hi;
        logic        nodly;

        phase_next   = phase_reg;
        wc_next      = wc_reg;
        shift_next   = shift_reg;
        bit_next     = bit_reg;
        bytes_next   = bytes_reg;
        prev_rd_next = prev_rd_reg;
        open_next    = open_reg;
        rd_flag_next = rd_flag_reg;
        nostop_next  = nostop_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        res_next     = '0;
        accepted     = 1'b0;
        rem          = 9'd0;

        if (item.command != i2cmbs_pkg::CMD_TICK) begin
            if (phase_reg == PH_IDLE) begin
                unique case (item.command)
                    i2cmbs_pkg::CMD_HEADER: begin
                        if (bytes_reg == 16'd0) begin
                            accepted     = 1'b1;
                            rd_flag_next = item.read_message;
                            nostop_next  = item.no_stop;
                            bytes_next   = item.byte_count;
                            wc_next      = 17'd0;
                            if (!open_reg || prev_rd_reg != item.read_message) begin
                                shift_next = {item.device_address, item.read_message};
                                bit_next   = 4'd0;
                                phase_next = PH_START_SCLH;
                            end else begin
                                phase_next = PH_POST_SCLL;
                            end
                            open_next    = 1'b1;
                            prev_rd_next = item.read_message;
                        end
                    end
                    i2cmbs_pkg::CMD_WRITE: begin
                        if (bytes_reg != 16'd0 && !rd_flag_reg) begin
                            accepted   = 1'b1;
                            bytes_next = bytes_reg - 16'd1;
                            shift_next = item.write_data;
                            bit_next   = 4'd0;
                            phase_next = PH_BIT_SDA;
                            wc_next    = 17'd0;
                        end
                    end
                    i2cmbs_pkg::CMD_READ: begin
                        if (bytes_reg != 16'd0 && rd_flag_reg) begin
                            accepted   = 1'b1;
                            bytes_next = bytes_reg - 16'd1;
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            phase_next = PH_RD_SDAH;
                            wc_next    = 17'd0;
                        end
                    end
                    i2cmbs_pkg::CMD_END: begin
                        accepted   = 1'b1;
                        bytes_next = 16'd0;
                        open_next  = 1'b0;
                        phase_next = PH_REL_SCLH;
                        wc_next    = 17'd0;
                    end
                    default: accepted = 1'b0;
                endcase
            end
            if (!accepted) begin
                res_next.status = i2cmbs_pkg::ST_REJECT;
            end
        end

        // SCL edges: pick direction and whether the half period applies
        hi    = (phase_next == PH_START_SCLH) || (phase_next == PH_BIT_SCLH) ||
                (phase_next == PH_ACK_SCLH) || (phase_next == PH_RD_SCLH) ||
                (phase_next == PH_RD_ASCLH) || (phase_next == PH_STOP_SCLH) ||
                (phase_next == PH_REL_SCLH);
        nodly = (phase_next == PH_ACK_SCLH) || (phase_next == PH_STOP_SCLH);
        dly   = (timing.delay_en && !nodly) ? timing.half_period : 9'd0;
        sr    = scl_step(wc_next, dly, hi, timing.stretch_en, item.scl_level,
                         timing.ack_timeout);

        unique case (phase_next)
            PH_IDLE: ;
            PH_START_SDAL: begin
                sda_next = 1'b0; phase_next = PH_START_SCLL; wc_next = 17'd0;
            end
            PH_BIT_SDA: begin
                sda_next   = shift_next[3'd7 - bit_next[2:0]];
                phase_next = PH_BIT_SCLH; wc_next = 17'd0;
            end
            PH_ACK_SDAH: begin
                sda_next = 1'b1; phase_next = PH_ACK_SCLH; wc_next = 17'd0;
            end
            PH_ACK_POLL: begin
                if (wc_next >= {1'b0, timing.ack_timeout}) begin
                    res_next.status       = i2cmbs_pkg::ST_NOACK;
                    res_next.message_done = 1'b1;
                    bytes_next = 16'd0;
                    open_next  = 1'b0;
                    phase_next = PH_REL_SCLH; wc_next = 17'd0;
                end else if (!item.sda_level) begin
                    if (timing.delay_en && ({8'd0, timing.half_period} > wc_next)) begin
                        rem = timing.half_period - wc_next[8:0];
                    end
                    if (rem != 9'd0) begin
                        phase_next = PH_ACK_REST; wc_next = {8'd0, rem};
                    end else begin
                        phase_next = PH_POST_SCLL; wc_next = 17'd0;
                    end
                end else begin
                    wc_next = wc_next + 17'd1;
                end
            end
            PH_ACK_REST: begin
                if (wc_next > 17'd1) begin
                    wc_next = wc_next - 17'd1;
                end else begin
                    phase_next = PH_POST_SCLL; wc_next = 17'd0;
                end
            end
            PH_RD_SDAH: begin
                sda_next = 1'b1; phase_next = PH_RD_SCLH; wc_next = 17'd0;
            end
            PH_RD_ASDA: begin
                sda_next   = (bytes_next == 16'd0);
                phase_next = PH_RD_ASCLH; wc_next = 17'd0;
            end
            PH_STOP_SDAL: begin
                sda_next = 1'b0; phase_next = PH_STOP_SCLH; wc_next = 17'd0;
            end
            PH_STOP_SDAH: begin
                sda_next = 1'b1; res_next.message_done = 1'b1;
                phase_next = PH_IDLE; wc_next = 17'd0;
            end
            PH_REL_SDAH: begin
                sda_next = 1'b1; phase_next = PH_IDLE; wc_next = 17'd0;
            end
            default: begin
                // every remaining phase is an SCL edge
                if (wc_next == 17'd0) begin
                    scl_next = hi;
                end
                wc_next = sr.wc;
                if (sr.done) begin
                    unique case (phase_next)
                        PH_START_SCLH: phase_next = PH_START_SDAL;
                        PH_START_SCLL: phase_next = PH_BIT_SDA;
                        PH_BIT_SCLH:   phase_next = PH_BIT_SCLL;
                        PH_BIT_SCLL: begin
                            bit_next   = bit_next + 4'd1;
                            phase_next = bit_next[3] ? PH_ACK_SDAH : PH_BIT_SDA;
                        end
                        PH_ACK_SCLH:   phase_next = PH_ACK_POLL;
                        PH_RD_SCLH: begin
                            shift_next = {shift_next[6:0], item.sda_level};
                            phase_next = PH_RD_SCLL;
                        end
                        PH_RD_SCLL: begin
                            bit_next   = bit_next + 4'd1;
                            phase_next = bit_next[3] ? PH_RD_ASDA : PH_RD_SCLH;
                        end
                        PH_RD_ASCLH:   phase_next = PH_RD_ASCLL;
                        PH_STOP_SCLH:  phase_next = PH_STOP_SDAH;
                        PH_REL_SCLH:   phase_next = PH_REL_SDAH;
                        PH_POST_SCLL, PH_RD_ASCLL: begin
                            if (phase_next == PH_RD_ASCLL) begin
                                res_next.read_valid = 1'b1;
                                res_next.read_data  = shift_next;
                            end
                            if (bytes_next == 16'd0) begin
                                if (nostop_next) begin
                                    res_next.message_done = 1'b1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    phase_next = PH_STOP_SDAL;
                                end
                            end else begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        endcase

        res_next.scl_drive = scl_next;
        res_next.sda_drive = sda_next;
        res_next.ready_res = (phase_next == PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            wc_reg      <= 17'd0;
            shift_reg   <= 8'd0;
            bit_reg     <= 4'd0;
            bytes_reg   <= 16'd0;
            prev_rd_reg <= 1'b0;
            open_reg    <= 1'b0;
            rd_flag_reg <= 1'b0;
            nostop_reg  <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            valid_reg   <= 1'b0;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                wc_reg      <= wc_next;
                shift_reg   <= shift_next;
                bit_reg     <= bit_next;
                bytes_reg   <= bytes_next;
                prev_rd_reg <= prev_rd_next;
                open_reg    <= open_next;
                rd_flag_reg <= rd_flag_next;
                nostop_reg  <= nostop_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                res_reg     <= res_next;
                valid_reg   <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = res_reg;

endmodule

[rtl/i2c_master_bit_sequencer.sv]
// Top level: configuration registers, input queue, half-period divider and bus sequencer.
// An item at the head of the queue is stepped once the divider is idle and the result
// register has room, and its result is registered in the sequencer's result register.
// Throughput: one item per cycle while the divider is idle and results are taken, set by
// the single-tick sequencer step. A write to the frequency or overhead register holds off
// items and further writes while the serial divider runs (none for a frequency of zero).
// Reset is synchronous, active low.
module i2c_master_bit_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  i2cmbs_pkg::item_in_t                  s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output i2cmbs_pkg::item_out_t                 m_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2cmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [i2cmbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [19:0] freq_reg;
    logic [7:0]  ovh_reg;
    logic [15:0] tmo_reg;
    logic        stretch_reg;
    logic        delay_reg;

    logic        cfg_wr;
    logic        div_start;
    logic        div_busy;
    logic [8:0]  half_period;
    logic        q_empty;
    logic        q_full;
    logic        step;
    i2cmbs_pkg::item_in_t head_item;
    i2cmbs_pkg::timing_t  timing;

    assign cfg_ready = !div_busy;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign div_start = cfg_wr && (cfg_index == i2cmbs_pkg::CFG_FREQ ||
                                  cfg_index == i2cmbs_pkg::CFG_OVH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg    <= i2cmbs_pkg::FREQ_RESET;
            ovh_reg     <= i2cmbs_pkg::OVH_RESET;
            tmo_reg     <= i2cmbs_pkg::TIMEOUT_RESET;
            stretch_reg <= 1'b0;
            delay_reg   <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                i2cmbs_pkg::CFG_FREQ:    freq_reg    <= cfg_data[19:0];
                i2cmbs_pkg::CFG_OVH:     ovh_reg     <= cfg_data[7:0];
                i2cmbs_pkg::CFG_TIMEOUT: tmo_reg     <= cfg_data[15:0];
                i2cmbs_pkg::CFG_STRETCH: stretch_reg <= cfg_data[0];
                i2cmbs_pkg::CFG_DELAY:   delay_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    i2cmbs_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (div_start),
        .freq_in     ((cfg_index == i2cmbs_pkg::CFG_FREQ) ? cfg_data[19:0] : freq_reg),
        .ovh_in      ((cfg_index == i2cmbs_pkg::CFG_OVH) ? cfg_data[7:0] : ovh_reg),
        .busy        (div_busy),
        .half_period (half_period)
    );

    assign s_ready = !q_full;

    i2cmbs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (s_item),
        .pop       (step),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    // advance only with an item queued, the divider settled and room in the result register
    assign step = !q_empty && !div_busy && (!m_valid || m_ready);

    assign timing.ack_timeout = tmo_reg;
    assign timing.stretch_en  = stretch_reg;
    assign timing.delay_en    = delay_reg;
    assign timing.half_period = half_period;

    i2cmbs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (head_item),
        .timing  (timing),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule

[rtl/i2cmbs_checker.sv]
// Port-level checks on the result channel of the bit sequencer.
module i2cmbs_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input i2cmbs_pkg::item_out_t m_item
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item dropped or changed while stalled");

    a_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.read_valid |-> m_item.read_data == 8'd0)
        else $error("read data without a received byte");

    a_noack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == i2cmbs_pkg::ST_NOACK |->
            m_item.message_done && !m_item.ready_res)
        else $error("ACK abort must end the message and release the lines");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown straight after reset");

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
